// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_START_MARKER = 3'd0;
    localparam logic [2:0] REG_OWN_ADDRESS  = 3'd1;
    localparam logic [2:0] REG_BCAST_ADDR   = 3'd2;
    localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT      = 3'd4;

    localparam logic [7:0]  RST_START_MARKER = 8'd0;
    localparam logic [7:0]  RST_OWN_ADDRESS  = 8'd1;
    localparam logic [7:0]  RST_BCAST_ADDR   = 8'd255;
    localparam logic [7:0]  RST_MAX_PAYLOAD  = 8'd255;
    localparam logic [31:0] RST_TIMEOUT      = 32'd1000;

    localparam logic [7:0] ID_FLAG = 8'h80;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HDR_HASH = 3'd1,
        ST_PAY_HASH = 3'd2,
        ST_OVERSIZE = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_BAD_ID   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  own_address;
        logic [7:0]  broadcast_address;
        logic [7:0]  max_payload_length;
        logic [31:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       end_of_frame;
        logic [7:0] data_byte;
        logic [7:0] station_address;
        logic [7:0] packet_number;
        logic [7:0] command_code;
        logic [7:0] payload_count;
        logic       is_broadcast;
        t_status    status;
    } t_result;

endpackage

// ===== rtl/core/serial_frame_receiver.sv =====
// Receiver for start-byte framed packets. Each input transaction is a
// received byte (i_mode 0) or one time tick (i_mode 1). A frame is the start
// marker, a header of address, packet id, command, length and XOR hash,
// then the payload and, if the length is not zero, an XOR payload hash.
// Frames for the own or broadcast address give one output transaction per
// payload byte and one frame-end transaction with the header fields and a
// status; foreign frames are consumed silently, except that oversize and
// header hash errors and header timeouts are always reported. Each input
// transaction is handled in the cycle it is accepted, one per clock unless
// o_stall is high, by the frame state registers; results go to a two-entry
// output register with skid; o_stall rises only while both entries are full.
// Users write registers over the APB port while no frame is in progress; not enforced.
module serial_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_end_of_frame,
    output logic [7:0]                     o_data_byte,
    output logic [7:0]                     o_station_address,
    output logic [7:0]                     o_packet_number,
    output logic [7:0]                     o_command_code,
    output logic [7:0]                     o_payload_count,
    output logic                           o_is_broadcast,
    output logic [2:0]                     o_status
);
    import sfr_pkg::*;

    t_cfg    cfg;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_full;

    assign o_stall = buf_full;
    assign accept  = i_valid & ~buf_full;

    sfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_end_of_frame    = out_res.end_of_frame;
    assign o_data_byte       = out_res.data_byte;
    assign o_station_address = out_res.station_address;
    assign o_packet_number   = out_res.packet_number;
    assign o_command_code    = out_res.command_code;
    assign o_payload_count   = out_res.payload_count;
    assign o_is_broadcast    = out_res.is_broadcast;
    assign o_status          = out_res.status;

endmodule

// ===== rtl/core/sfr_cfg.sv =====
module sfr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output sfr_pkg::t_cfg                 o_cfg
);
    import sfr_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker       <= RST_START_MARKER;
            r_cfg.own_address        <= RST_OWN_ADDRESS;
            r_cfg.broadcast_address  <= RST_BCAST_ADDR;
            r_cfg.max_payload_length <= RST_MAX_PAYLOAD;
            r_cfg.timeout_ticks      <= RST_TIMEOUT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_MARKER: r_cfg.start_marker       <= pwdata[7:0];
                REG_OWN_ADDRESS:  r_cfg.own_address        <= pwdata[7:0];
                REG_BCAST_ADDR:   r_cfg.broadcast_address  <= pwdata[7:0];
                REG_MAX_PAYLOAD:  r_cfg.max_payload_length <= pwdata[7:0];
                REG_TIMEOUT:      r_cfg.timeout_ticks      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_MARKER: prdata = {24'd0, r_cfg.start_marker};
            REG_OWN_ADDRESS:  prdata = {24'd0, r_cfg.own_address};
            REG_BCAST_ADDR:   prdata = {24'd0, r_cfg.broadcast_address};
            REG_MAX_PAYLOAD:  prdata = {24'd0, r_cfg.max_payload_length};
            REG_TIMEOUT:      prdata = r_cfg.timeout_ticks;
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/sfr_core.sv =====
module sfr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_cfg    i_cfg,
    input  logic             i_accept,
    input  logic             i_mode,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_PHASH
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_hdr [4];
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    logic [31:0] r_idle, n_idle;
    logic        r_to_us, n_to_us;

    logic        hdr_we;
    logic        do_end;
    logic [7:0]  fld [4];
    logic        addr_known;
    logic [31:0] limit;
    logic [31:0] idle_inc;
    logic [7:0]  xor_next;
    logic [7:0]  pos_inc;
    logic        res_eof;
    logic [7:0]  res_data;
    t_status     res_status;

    // fields not yet received in the current header read as zero
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_phase == PH_HEADER && r_pos <= 8'(k)) begin
                fld[k] = 8'd0;
            end else begin
                fld[k] = r_hdr[k];
            end
        end
    end

    assign addr_known = !(r_phase == PH_HEADER && r_pos == 8'd0);
    assign limit      = (i_cfg.timeout_ticks == 32'd0) ? 32'd1 : i_cfg.timeout_ticks;
    assign idle_inc   = (r_idle == 32'hFFFF_FFFF) ? r_idle : r_idle + 32'd1;
    assign xor_next   = r_xor ^ i_rx_byte;
    assign pos_inc    = r_pos + 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_xor       = r_xor;
        n_idle      = r_idle;
        n_to_us     = r_to_us;
        hdr_we      = 1'b0;
        do_end      = 1'b0;
        o_res_valid = 1'b0;
        res_eof     = 1'b0;
        res_data    = 8'd0;
        res_status  = ST_OK;
        if (i_accept) begin
            if (i_mode) begin
                if (r_phase != PH_HUNT) begin
                    n_idle = idle_inc;
                    if (idle_inc >= limit) begin
                        do_end      = 1'b1;
                        o_res_valid = (r_phase == PH_HEADER) || r_to_us;
                        res_eof     = 1'b1;
                        res_status  = ST_TIMEOUT;
                    end
                end
            end else begin
                n_idle = 32'd0;
                case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == i_cfg.start_marker) begin
                            n_phase = PH_HEADER;
                            n_pos   = 8'd0;
                            n_xor   = 8'd0;
                            n_to_us = 1'b0;
                        end
                    end
                    PH_HEADER: begin
                        if (r_pos < 8'd4) begin
                            hdr_we = 1'b1;
                            n_xor  = xor_next;
                            n_pos  = pos_inc;
                            if (r_pos == 8'd0) begin
                                n_to_us = (i_rx_byte == i_cfg.own_address)
                                       || (i_rx_byte == i_cfg.broadcast_address);
                            end
                        end else if (r_hdr[3] > i_cfg.max_payload_length) begin
                            do_end      = 1'b1;
                            o_res_valid = 1'b1;
                            res_eof     = 1'b1;
                            res_status  = ST_OVERSIZE;
                        end else if (i_rx_byte != r_xor) begin
                            do_end      = 1'b1;
                            o_res_valid = 1'b1;
                            res_eof     = 1'b1;
                            res_status  = ST_HDR_HASH;
                        end else if (r_hdr[3] == 8'd0) begin
                            do_end      = 1'b1;
                            o_res_valid = r_to_us;
                            res_eof     = 1'b1;
                            res_status  = ((r_hdr[1] & ID_FLAG) != 8'd0) ? ST_BAD_ID : ST_OK;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_pos   = 8'd0;
                            n_xor   = 8'd0;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_xor       = xor_next;
                        n_pos       = pos_inc;
                        o_res_valid = r_to_us;
                        res_data    = i_rx_byte;
                        if (pos_inc >= r_hdr[3]) begin
                            n_phase = PH_PHASH;
                        end
                    end
                    PH_PHASH: begin
                        do_end      = 1'b1;
                        o_res_valid = r_to_us;
                        res_eof     = 1'b1;
                        if (i_rx_byte != r_xor) begin
                            res_status = ST_PAY_HASH;
                        end else if ((r_hdr[1] & ID_FLAG) != 8'd0) begin
                            res_status = ST_BAD_ID;
                        end else begin
                            res_status = ST_OK;
                        end
                    end
                    default: begin
                        do_end = 1'b1;
                    end
                endcase
            end
            if (do_end) begin
                n_phase = PH_HUNT;
                n_pos   = 8'd0;
                n_xor   = 8'd0;
                n_idle  = 32'd0;
            end
        end
    end

    always_comb begin
        o_res.end_of_frame    = res_eof;
        o_res.data_byte       = res_data;
        o_res.station_address = fld[0];
        o_res.packet_number   = fld[1];
        o_res.command_code    = fld[2];
        o_res.payload_count   = fld[3];
        o_res.is_broadcast    = addr_known && (fld[0] == i_cfg.broadcast_address);
        o_res.status          = res_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= 8'd0;
            r_xor   <= 8'd0;
            r_idle  <= 32'd0;
            r_to_us <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_idle  <= n_idle;
            r_to_us <= n_to_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_pos[1:0]] <= i_rx_byte;
        end
    end

endmodule

// ===== rtl/core/sfr_out_buf.sv =====
module sfr_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sfr_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output sfr_pkg::t_result o_res
);
    import sfr_pkg::*;

    logic    r_out_valid;
    logic    r_skd_valid;
    t_result r_out;
    t_result r_skd;
    logic    pop;

    assign pop     = r_out_valid & ~i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (pop) begin
                r_skd_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skd <= i_res;
            end
        end
    end

endmodule

// ===== verif/sfr_checker.sv =====
`timescale 1ns / 100ps

module sfr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           i_mode,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic                           o_end_of_frame,
    input  logic [7:0]                     o_data_byte,
    input  logic [7:0]                     o_station_address,
    input  logic [7:0]                     o_packet_number,
    input  logic [7:0]                     o_command_code,
    input  logic [7:0]                     o_payload_count,
    input  logic                           o_is_broadcast,
    input  logic [2:0]                     o_status,
    output int                             fail_count,
    output int                             pending_records,
    output int                             payload_seen,
    output int                             frame_end_seen
);
    import sfr_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_HEADER,
        RX_PAYLOAD,
        RX_PAY_HASH
    } t_rx_phase;

    t_cfg       cfg;
    t_rx_phase  rx_phase;
    logic [7:0] hdr [4];
    logic [7:0] byte_pos;
    logic [7:0] xor_acc;
    logic [31:0] idle_count;
    logic       for_us;
    t_result    awaited_records [$];
    t_result    observed;

    // header fields not yet received in this frame read as zero
    function automatic t_result frame_record(input logic eof, input logic [7:0] data,
                                             input t_status st);
        t_result    rec;
        logic [7:0] f [4];
        for (int i = 0; i < 4; i++)
            f[i] = (rx_phase == RX_HEADER && i >= byte_pos) ? 8'h00 : hdr[i];
        rec.end_of_frame    = eof;
        rec.data_byte       = data;
        rec.station_address = f[0];
        rec.packet_number   = f[1];
        rec.command_code    = f[2];
        rec.payload_count   = f[3];
        rec.is_broadcast    = !(rx_phase == RX_HEADER && byte_pos == 8'd0)
                              && f[0] == cfg.broadcast_address;
        rec.status          = eof ? st : ST_OK;
        return rec;
    endfunction

    task automatic close_frame(input t_status st, input logic report);
        if (report)
            awaited_records.push_back(frame_record(1'b1, 8'h00, st));
        rx_phase   = RX_HUNT;
        byte_pos   = 8'd0;
        xor_acc    = 8'h00;
        idle_count = 32'd0;
    endtask

    task automatic advance_receiver(input logic mode, input logic [7:0] b);
        t_status     st;
        logic [31:0] limit;
        limit = (cfg.timeout_ticks == 32'd0) ? 32'd1 : cfg.timeout_ticks;
        if (mode) begin
            if (rx_phase != RX_HUNT) begin
                if (idle_count != 32'hFFFF_FFFF)
                    idle_count++;
                if (idle_count >= limit)
                    close_frame(ST_TIMEOUT, rx_phase == RX_HEADER || for_us);
            end
        end else begin
            idle_count = 32'd0;
            case (rx_phase)
                RX_HUNT: begin
                    if (b == cfg.start_marker) begin
                        rx_phase = RX_HEADER;
                        byte_pos = 8'd0;
                        xor_acc  = 8'h00;
                        for_us   = 1'b0;
                    end
                end
                RX_HEADER: begin
                    if (byte_pos < 8'd4) begin
                        hdr[byte_pos[1:0]] = b;
                        xor_acc ^= b;
                        if (byte_pos == 8'd0)
                            for_us = (b == cfg.own_address) || (b == cfg.broadcast_address);
                        byte_pos++;
                    end else if (hdr[3] > cfg.max_payload_length) begin
                        close_frame(ST_OVERSIZE, 1'b1);
                    end else if (b != xor_acc) begin
                        close_frame(ST_HDR_HASH, 1'b1);
                    end else begin
                        rx_phase = RX_PAYLOAD;
                        byte_pos = 8'd0;
                        xor_acc  = 8'h00;
                        if (hdr[3] == 8'd0) begin
                            st = ((hdr[1] & ID_FLAG) != 8'h00) ? ST_BAD_ID : ST_OK;
                            close_frame(st, for_us);
                        end
                    end
                end
                RX_PAYLOAD: begin
                    xor_acc ^= b;
                    byte_pos++;
                    if (for_us)
                        awaited_records.push_back(frame_record(1'b0, b, ST_OK));
                    if (byte_pos >= hdr[3])
                        rx_phase = RX_PAY_HASH;
                end
                default: begin
                    if (b != xor_acc)
                        st = ST_PAY_HASH;
                    else if ((hdr[1] & ID_FLAG) != 8'h00)
                        st = ST_BAD_ID;
                    else
                        st = ST_OK;
                    close_frame(st, for_us);
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < MAX_REPORTS)
            $display("%0t: transaction %0d: %s mismatch, got %0h expected %0h",
                     $time, payload_seen + frame_end_seen, what, got, want);
        fail_count++;
    endtask

    task automatic check_record(input t_result got);
        t_result want;
        if (awaited_records.size() == 0) begin
            report_mismatch("unexpected record", 64'(got), 64'd0);
        end else begin
            want = awaited_records.pop_front();
            if (got.end_of_frame !== want.end_of_frame)
                report_mismatch("end_of_frame", 64'(got.end_of_frame), 64'(want.end_of_frame));
            if (got.data_byte !== want.data_byte)
                report_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
            if (got.station_address !== want.station_address)
                report_mismatch("station_address", 64'(got.station_address),
                                64'(want.station_address));
            if (got.packet_number !== want.packet_number)
                report_mismatch("packet_number", 64'(got.packet_number),
                                64'(want.packet_number));
            if (got.command_code !== want.command_code)
                report_mismatch("command_code", 64'(got.command_code), 64'(want.command_code));
            if (got.payload_count !== want.payload_count)
                report_mismatch("payload_count", 64'(got.payload_count),
                                64'(want.payload_count));
            if (got.is_broadcast !== want.is_broadcast)
                report_mismatch("is_broadcast", 64'(got.is_broadcast), 64'(want.is_broadcast));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        end
        if (got.end_of_frame)
            frame_end_seen++;
        else
            payload_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.start_marker       = RST_START_MARKER;
            cfg.own_address        = RST_OWN_ADDRESS;
            cfg.broadcast_address  = RST_BCAST_ADDR;
            cfg.max_payload_length = RST_MAX_PAYLOAD;
            cfg.timeout_ticks      = RST_TIMEOUT;
            rx_phase   = RX_HUNT;
            byte_pos   = 8'd0;
            xor_acc    = 8'h00;
            idle_count = 32'd0;
            for_us     = 1'b0;
            awaited_records.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_START_MARKER: cfg.start_marker       = pwdata[7:0];
                    REG_OWN_ADDRESS:  cfg.own_address        = pwdata[7:0];
                    REG_BCAST_ADDR:   cfg.broadcast_address  = pwdata[7:0];
                    REG_MAX_PAYLOAD:  cfg.max_payload_length = pwdata[7:0];
                    REG_TIMEOUT:      cfg.timeout_ticks      = pwdata[31:0];
                    default: ;
                endcase
            end
            // push before pop so a same-cycle result would still line up
            if (i_valid && !o_stall)
                advance_receiver(i_mode, i_rx_byte);
            if (o_valid && !i_stall) begin
                observed.end_of_frame    = o_end_of_frame;
                observed.data_byte       = o_data_byte;
                observed.station_address = o_station_address;
                observed.packet_number   = o_packet_number;
                observed.command_code    = o_command_code;
                observed.payload_count   = o_payload_count;
                observed.is_broadcast    = o_is_broadcast;
                observed.status          = t_status'(o_status);
                check_record(observed);
            end
        end
        pending_records = awaited_records.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import sfr_pkg::*;

    localparam int   CLK_PERIOD       = 20;
    localparam int   LIMIT_CYCLES     = 500000;
    localparam int   NUM_PHASES       = 7;
    localparam int   RANDOM_PER_PHASE = 115;
    localparam int   LONG_HOLD        = 300;
    localparam int   DRAIN_TAIL       = 8;
    localparam logic MODE_BYTE        = 1'b0;
    localparam logic MODE_TICK        = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_mode;
    logic [7:0]            i_rx_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_end_of_frame;
    logic [7:0]            o_data_byte;
    logic [7:0]            o_station_address;
    logic [7:0]            o_packet_number;
    logic [7:0]            o_command_code;
    logic [7:0]            o_payload_count;
    logic                  o_is_broadcast;
    logic [2:0]            o_status;

    int fail_count;
    int pending_records;
    int payload_seen;
    int frame_end_seen;

    int          items_sent;
    int unsigned cycle_count;
    bit          no_idle;
    bit          hold_request;

    logic [7:0]  cur_start;
    logic [7:0]  cur_own;
    logic [7:0]  cur_bcast;
    logic [7:0]  cur_max;
    logic [31:0] cur_timeout;

    serial_frame_receiver DUT (.*);

    sfr_checker record_checker (.*);

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_count);
        $display("serial_frame_receiver verification failed");
        $finish;
    end

    // output side: random stall, plus one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_stall <= !no_idle && ($urandom_range(99) < 32);
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] b);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic wait_records_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_records != 0) @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] marker, input logic [7:0] own,
                                  input logic [7:0] bcast, input logic [7:0] maxlen,
                                  input logic [31:0] ticks);
        cur_start   = marker;
        cur_own     = own;
        cur_bcast   = bcast;
        cur_max     = maxlen;
        cur_timeout = ticks;
        write_register(REG_START_MARKER, {24'd0, marker});
        write_register(REG_OWN_ADDRESS, {24'd0, own});
        write_register(REG_BCAST_ADDR, {24'd0, bcast});
        write_register(REG_MAX_PAYLOAD, {24'd0, maxlen});
        write_register(REG_TIMEOUT, ticks);
    endtask

    // cut_short stops the frame early and, for short timeouts, ticks it out
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] pid,
                              input logic [7:0] cmd, input int len, input bit bad_hdr,
                              input bit bad_pay, input bit cut_short);
        logic [7:0] frame_bytes [$];
        logic [7:0] hash;
        logic [7:0] b;
        int         cut_at;
        frame_bytes = {cur_start, addr, pid, cmd, 8'(len)};
        hash = addr ^ pid ^ cmd ^ 8'(len);
        frame_bytes.push_back(bad_hdr ? hash ^ (8'h01 << $urandom_range(7)) : hash);
        if (!bad_hdr && len > 0 && len <= int'(cur_max)) begin
            hash = 8'h00;
            for (int i = 0; i < len; i++) begin
                b = ($urandom_range(5) == 0) ? cur_start : 8'($urandom);
                frame_bytes.push_back(b);
                hash ^= b;
            end
            frame_bytes.push_back(bad_pay ? hash ^ (8'h01 << $urandom_range(7)) : hash);
        end
        cut_at = $urandom_range(1, frame_bytes.size() - 1);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (cut_short && i == cut_at)
                break;
            if (i > 0 && cur_timeout > 1 && $urandom_range(9) == 0)
                repeat ($urandom_range(1, cur_timeout > 3 ? 3 : int'(cur_timeout) - 1))
                    send_item(MODE_TICK, 8'($urandom));
            send_item(MODE_BYTE, frame_bytes[i]);
        end
        if (cut_short && cur_timeout <= 64)
            repeat (cur_timeout) send_item(MODE_TICK, 8'($urandom));
    endtask

    task automatic send_random_frame();
        int         r;
        int         len;
        logic [7:0] addr;
        r = $urandom_range(99);
        addr = (r < 40) ? cur_own : (r < 65) ? cur_bcast : 8'($urandom);
        r = $urandom_range(99);
        if (r < 3)
            len = int'(cur_max);
        else if (r < 8 && cur_max < 8'd255)
            len = $urandom_range(int'(cur_max) + 1, 255);
        else if (r < 25)
            len = $urandom_range(0, cur_max < 8'd40 ? int'(cur_max) : 40);
        else
            len = $urandom_range(0, cur_max < 8'd6 ? int'(cur_max) : 6);
        send_frame(addr, 8'($urandom), 8'($urandom), len, $urandom_range(99) < 8,
                   $urandom_range(99) < 8, $urandom_range(99) < 8);
    endtask

    initial begin
        int goal;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_valid      = 1'b0;
        i_mode       = MODE_BYTE;
        i_rx_byte    = 8'h00;
        items_sent   = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                // run any open frame to its end before touching registers
                if (cur_timeout < 32'(cur_max) + 32'd6)
                    repeat (cur_timeout) send_item(MODE_TICK, 8'h00);
                else
                    repeat (int'(cur_max) + 6) send_item(MODE_BYTE, cur_start ^ 8'h5A);
                wait_records_drained();
            end
            no_idle = (p == 2);
            case (p)
                0: apply_settings(8'hA5, 8'h12, 8'hFF, 8'd20, 32'd3);
                1: apply_settings(RST_START_MARKER, RST_OWN_ADDRESS, RST_BCAST_ADDR,
                                  RST_MAX_PAYLOAD, RST_TIMEOUT);
                2: apply_settings(8'hFF, 8'h00, 8'h00, 8'h00, 32'd1);
                3: apply_settings(8'h7E, 8'hFF, 8'h80, 8'hFF, 32'hFFFF_FFFF);
                default: apply_settings(8'($urandom), 8'($urandom),
                                        $urandom_range(1) ? 8'hFF : 8'($urandom),
                                        8'($urandom_range(64)), $urandom_range(1, 24));
            endcase

            if (p == 0) begin
                // tick while hunting
                send_item(MODE_TICK, 8'h00);
                // own frame, marker byte inside the payload
                send_item(MODE_BYTE, cur_start);
                send_item(MODE_BYTE, 8'h12);
                send_item(MODE_BYTE, 8'h00);
                send_item(MODE_BYTE, 8'hC3);
                send_item(MODE_BYTE, 8'h02);
                send_item(MODE_BYTE, 8'h12 ^ 8'h00 ^ 8'hC3 ^ 8'h02);
                send_item(MODE_BYTE, cur_start);
                send_item(MODE_BYTE, 8'hFF);
                send_item(MODE_BYTE, cur_start ^ 8'hFF);
                // broadcast, empty payload, packet id flagged
                send_item(MODE_BYTE, cur_start);
                send_item(MODE_BYTE, 8'hFF);
                send_item(MODE_BYTE, 8'h80);
                send_item(MODE_BYTE, 8'h01);
                send_item(MODE_BYTE, 8'h00);
                send_item(MODE_BYTE, 8'hFF ^ 8'h80 ^ 8'h01);
                // foreign address, oversize length with a bad header hash
                send_item(MODE_BYTE, cur_start);
                send_item(MODE_BYTE, 8'h33);
                send_item(MODE_BYTE, 8'h7F);
                send_item(MODE_BYTE, 8'h02);
                send_item(MODE_BYTE, 8'h15);
                send_item(MODE_BYTE, 8'h00);
                // timeout partway through the header
                send_item(MODE_BYTE, cur_start);
                send_item(MODE_BYTE, 8'h12);
                repeat (3) send_item(MODE_TICK, 8'hFF);
            end

            if (p == 1) begin
                hold_request = 1'b1;
                send_frame(cur_own, 8'h05, 8'h3C, 48, 1'b0, 1'b0, 1'b0);
                wait_records_drained();
            end

            goal = items_sent + RANDOM_PER_PHASE;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 85)
                    send_random_frame();
                else
                    repeat ($urandom_range(1, 4))
                        send_item($urandom_range(1) ? MODE_TICK : MODE_BYTE, 8'($urandom));
            end
        end

        wait_records_drained();
        $display("%0d input transactions over %0d register settings", items_sent, NUM_PHASES);
        $display("%0d payload and %0d frame-end records checked", payload_seen, frame_end_seen);
        if (fail_count == 0 && pending_records == 0)
            $display("serial_frame_receiver verification clean");
        else
            $display("serial_frame_receiver verification failed");
        $finish;
    end

endmodule

// ===== serial_frame_receiver.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_cfg.sv
rtl/core/sfr_core.sv
rtl/core/sfr_out_buf.sv
rtl/core/serial_frame_receiver.sv
verif/sfr_checker.sv
verif/testbench.sv
